// ===== sv/ookrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ookrs_pkg
// Shared types and constants of the on-off-keyed remote switch frame encoder:
// register indexes, item kinds, reset values and the segment descriptor.
// ----------------------------------------------------------------------------
package ookrs_pkg;

  localparam int CODE_BITS  = 5;
  localparam int UNIT_BITS  = 8;
  localparam int TICK_BITS  = 10;
  localparam int REP_BITS   = 4;
  localparam int INDEX_BITS = 3;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_TICKS_PER_UNIT  = 3'd0,
    REG_FRAME_REPEATS   = 3'd1,
    REG_START_GAP_UNITS = 3'd2,
    REG_SHORT_UNITS     = 3'd3,
    REG_LONG_UNITS      = 3'd4,
    REG_END_GAP_UNITS   = 3'd5
  } reg_index_t;

  localparam logic KIND_SEND = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [TICK_BITS-1:0] RST_TICKS_PER_UNIT  = 10'd113;
  localparam logic [REP_BITS-1:0]  RST_FRAME_REPEATS   = 4'd4;
  localparam logic [UNIT_BITS-1:0] RST_START_GAP_UNITS = 8'd16;
  localparam logic [UNIT_BITS-1:0] RST_SHORT_UNITS     = 8'd2;
  localparam logic [UNIT_BITS-1:0] RST_LONG_UNITS      = 8'd9;
  localparam logic [UNIT_BITS-1:0] RST_END_GAP_UNITS   = 8'd100;

  typedef struct packed {
    logic [TICK_BITS-1:0] ticks_per_unit;
    logic [REP_BITS-1:0]  frame_repeats;
    logic [UNIT_BITS-1:0] start_gap_units;
    logic [UNIT_BITS-1:0] short_units;
    logic [UNIT_BITS-1:0] long_units;
    logic [UNIT_BITS-1:0] end_gap_units;
  } cfg_regs_t;

  typedef struct packed {
    logic [UNIT_BITS-1:0] units;
    logic                 level;
  } seg_t;

endpackage

// ===== sv/ookrs_segment_decode.sv =====
// ----------------------------------------------------------------------------
// ookrs_segment_decode
// Maps a frame segment number to its length in base units and its pin level,
// skipping an empty start gap.
// ----------------------------------------------------------------------------
module ookrs_segment_decode
  import ookrs_pkg::*;
#(
  parameter int FIELD_BITS = 5,
  localparam int NUM_SYMBOLS  = 2 * FIELD_BITS + 2,
  localparam int END_HIGH_SEG = 4 * NUM_SYMBOLS + 1,
  localparam int END_LOW_SEG  = 4 * NUM_SYMBOLS + 2,
  localparam int SEG_W        = $clog2(END_LOW_SEG + 1),
  localparam int WORD_W       = 2 * FIELD_BITS + 1
) (
  input  cfg_regs_t          cfg,
  input  logic [SEG_W-1:0]   seg_req,
  input  logic [WORD_W-1:0]  frame_word,
  output logic [SEG_W-1:0]   seg_idx,
  output seg_t               seg
);

  localparam int SYM_W    = $clog2(NUM_SYMBOLS);
  localparam int SYM_SPAN = 1 << SYM_W;

  logic [SEG_W-1:0]     k;
  logic [1:0]           part;
  logic [SYM_W-1:0]     sym;
  logic [SYM_SPAN-1:0]  sym_bits;
  logic                 bit_v;
  logic [UNIT_BITS-1:0] sh;
  logic [UNIT_BITS-1:0] lg;
  logic [UNIT_BITS-1:0] eg;

  assign sh = (cfg.short_units == '0) ? UNIT_BITS'(1) : cfg.short_units;
  assign lg = (cfg.long_units == '0) ? UNIT_BITS'(1) : cfg.long_units;
  assign eg = (cfg.end_gap_units == '0) ? UNIT_BITS'(1) : cfg.end_gap_units;

  // symbol order: field bits, then command pair (~off, off)
  assign sym_bits = SYM_SPAN'({frame_word[2*FIELD_BITS], ~frame_word[2*FIELD_BITS],
                               frame_word[2*FIELD_BITS-1:0]});

  always_comb begin
    seg_idx = seg_req;
    if (seg_req == '0 && cfg.start_gap_units == '0) begin
      seg_idx = SEG_W'(1);
    end
    k     = seg_idx - SEG_W'(1);
    part  = k[1:0];
    sym   = k[SYM_W+1:2];
    bit_v = sym_bits[sym];

    if (seg_idx == '0) begin
      seg.level = 1'b0;
      seg.units = cfg.start_gap_units;
    end else if (seg_idx == SEG_W'(END_HIGH_SEG)) begin
      seg.level = 1'b1;
      seg.units = sh;
    end else if (seg_idx == SEG_W'(END_LOW_SEG)) begin
      seg.level = 1'b0;
      seg.units = eg;
    end else begin
      case (part)
        2'd0: begin
          seg.level = 1'b1;
          seg.units = sh;
        end
        2'd1: begin
          seg.level = 1'b0;
          seg.units = lg;
        end
        2'd2: begin
          seg.level = 1'b1;
          seg.units = bit_v ? sh : lg;
        end
        default: begin
          seg.level = 1'b0;
          seg.units = bit_v ? lg : sh;
        end
      endcase
    end
  end

endmodule

// ===== sv/ook_remote_switch_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_encoder
// On-off-keyed remote switch frame encoder driving one transmitter pin level
// from a stream of send requests and time ticks.
// ----------------------------------------------------------------------------
// Every request on the input stream gives exactly one result request on the
// output stream. A request is either a send (unit code, device id, off flag)
// or one time tick; a send while a sequence runs is rejected and flagged.
// One request is taken per clock cycle when the output is not stalled. Each
// request passes the input register, then an update of the prescaler, unit
// counter and segment sequencer into the result register. Configuration
// writes are always accepted.
module ook_remote_switch_frame_encoder
  import ookrs_pkg::*;
#(
  parameter int FIELD_BITS = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // unit_code[4:0], device_id[9:5], switch_off[10]
  input  logic                  in_tuser,   // kind

  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // pin_level, busy_res, sequence_done, rejected

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]  cfg_data
);

  localparam int NUM_SYMBOLS = 2 * FIELD_BITS + 2;
  localparam int END_LOW_SEG = 4 * NUM_SYMBOLS + 2;
  localparam int SEG_W       = $clog2(END_LOW_SEG + 1);
  localparam int WORD_W      = 2 * FIELD_BITS + 1;

  cfg_regs_t cfg_r;

  logic                 in_valid_r;
  logic                 in_kind_r;
  logic [CODE_BITS-1:0] in_unit_r;
  logic [CODE_BITS-1:0] in_dev_r;
  logic                 in_off_r;

  logic                 out_valid_r;
  logic [3:0]           out_flags_r;

  logic                 active_r, active_nxt;
  logic                 level_r, level_nxt;
  logic [SEG_W-1:0]     seg_r, seg_nxt;
  logic [TICK_BITS-1:0] presc_r, presc_nxt;
  logic [UNIT_BITS-1:0] units_r, units_nxt;
  logic [REP_BITS-1:0]  reps_r, reps_nxt;
  logic [WORD_W-1:0]    word_r, word_nxt;

  logic                 advance;
  logic                 proc;
  logic                 is_req;
  logic                 done;
  logic                 rej;
  logic [FIELD_BITS-1:0] unit_f;
  logic [FIELD_BITS-1:0] dev_f;
  logic [WORD_W-1:0]    new_word;
  logic [WORD_W-1:0]    word_sel;
  logic [SEG_W-1:0]     seg_req;
  logic [SEG_W-1:0]     seg_idx;
  seg_t                 seg;
  logic [TICK_BITS-1:0] tpu;
  logic [TICK_BITS-1:0] presc_inc;
  logic [UNIT_BITS-1:0] units_dec;
  logic [REP_BITS-1:0]  reps_dec;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign proc       = in_valid_r && advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_flags_r};
  assign cfg_ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_unit  <= RST_TICKS_PER_UNIT;
      cfg_r.frame_repeats   <= RST_FRAME_REPEATS;
      cfg_r.start_gap_units <= RST_START_GAP_UNITS;
      cfg_r.short_units     <= RST_SHORT_UNITS;
      cfg_r.long_units      <= RST_LONG_UNITS;
      cfg_r.end_gap_units   <= RST_END_GAP_UNITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICKS_PER_UNIT:  cfg_r.ticks_per_unit  <= cfg_data;
        REG_FRAME_REPEATS:   cfg_r.frame_repeats   <= cfg_data[REP_BITS-1:0];
        REG_START_GAP_UNITS: cfg_r.start_gap_units <= cfg_data[UNIT_BITS-1:0];
        REG_SHORT_UNITS:     cfg_r.short_units     <= cfg_data[UNIT_BITS-1:0];
        REG_LONG_UNITS:      cfg_r.long_units      <= cfg_data[UNIT_BITS-1:0];
        REG_END_GAP_UNITS:   cfg_r.end_gap_units   <= cfg_data[UNIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser;
      in_unit_r <= in_tdata[4:0];
      in_dev_r  <= in_tdata[9:5];
      in_off_r  <= in_tdata[10];
    end
  end

  // codes fitted to the field width
  always_comb begin
    for (int i = 0; i < FIELD_BITS; i++) begin
      unit_f[i] = (i < CODE_BITS) ? in_unit_r[i % CODE_BITS] : 1'b0;
      dev_f[i]  = (i < CODE_BITS) ? in_dev_r[i % CODE_BITS] : 1'b0;
    end
  end

  assign new_word  = {in_off_r, dev_f, unit_f};
  assign is_req    = (in_kind_r == KIND_SEND);
  assign word_sel  = is_req ? new_word : word_r;
  assign seg_req   = (is_req || seg_r >= SEG_W'(END_LOW_SEG)) ? '0 : seg_r + SEG_W'(1);
  assign tpu       = (cfg_r.ticks_per_unit == '0) ? TICK_BITS'(1) : cfg_r.ticks_per_unit;
  assign presc_inc = presc_r + TICK_BITS'(1);
  assign units_dec = (units_r != '0) ? units_r - UNIT_BITS'(1) : '0;
  assign reps_dec  = (reps_r != '0) ? reps_r - REP_BITS'(1) : '0;

  ookrs_segment_decode #(
    .FIELD_BITS (FIELD_BITS)
  ) u_segment_decode (
    .cfg        (cfg_r),
    .seg_req    (seg_req),
    .frame_word (word_sel),
    .seg_idx    (seg_idx),
    .seg        (seg)
  );

  always_comb begin
    active_nxt = active_r;
    level_nxt  = level_r;
    seg_nxt    = seg_r;
    presc_nxt  = presc_r;
    units_nxt  = units_r;
    reps_nxt   = reps_r;
    word_nxt   = word_r;
    done       = 1'b0;
    rej        = 1'b0;
    if (proc) begin
      if (is_req) begin
        if (active_r) begin
          rej = 1'b1;
        end else begin
          word_nxt   = new_word;
          reps_nxt   = (cfg_r.frame_repeats == '0) ? REP_BITS'(1) : cfg_r.frame_repeats;
          presc_nxt  = '0;
          active_nxt = 1'b1;
          seg_nxt    = seg_idx;
          units_nxt  = seg.units;
          level_nxt  = seg.level;
        end
      end else if (active_r) begin
        presc_nxt = presc_inc;
        if (presc_inc >= tpu) begin
          presc_nxt = '0;
          units_nxt = units_dec;
          if (units_dec == '0) begin
            if (seg_r >= SEG_W'(END_LOW_SEG)) begin
              reps_nxt = reps_dec;
              if (reps_dec == '0) begin
                active_nxt = 1'b0;
                level_nxt  = 1'b0;
                seg_nxt    = '0;
                done       = 1'b1;
              end else begin
                seg_nxt   = seg_idx;
                units_nxt = seg.units;
                level_nxt = seg.level;
              end
            end else begin
              seg_nxt   = seg_idx;
              units_nxt = seg.units;
              level_nxt = seg.level;
            end
          end
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      level_r  <= 1'b0;
      seg_r    <= '0;
      presc_r  <= '0;
      units_r  <= '0;
      reps_r   <= '0;
      word_r   <= '0;
    end else begin
      active_r <= active_nxt;
      level_r  <= level_nxt;
      seg_r    <= seg_nxt;
      presc_r  <= presc_nxt;
      units_r  <= units_nxt;
      reps_r   <= reps_nxt;
      word_r   <= word_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_flags_r <= {rej, done, active_nxt, level_nxt};
    end
  end

  a_idle_pin_low : assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> !level_r)
    else $error("pin high while no sequence is running");

  a_seg_range : assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= SEG_W'(END_LOW_SEG))
    else $error("segment number beyond end of frame");

  a_repeats_left : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> reps_r != '0)
    else $error("sequence running with no frames left");

  a_reject_holds : assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_req && active_r |=> $stable(word_r) && $stable(seg_r) && $stable(units_r))
    else $error("rejected send disturbed the running sequence");

  a_done_result : assert property (@(posedge clk) disable iff (!rst_n)
    proc && done |=> out_valid_r && out_flags_r[2] && !out_flags_r[1] && !out_flags_r[0])
    else $error("end of sequence result not idle and low");

endmodule

// ===== tb/ook_remote_switch_frame_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_encoder_tb
// Self-checking testbench for the on-off-keyed remote switch frame encoder.
// A local model of the segment sequencer predicts pin level, busy, done and
// reject flags for every accepted request. The results are checked in order
// against the output stream. Directed tests cover idle ticks, busy rejects,
// register extremes, zero settings and writes during a running sequence.
// Random traffic then mixes send requests and ticks under varying timing
// settings and back-pressure.
// ----------------------------------------------------------------------------
module ook_remote_switch_frame_encoder_tb;
  import ookrs_pkg::*;

  localparam int FIELD_W      = 5;
  localparam int NUM_SYMBOLS  = 2 * FIELD_W + 2;
  localparam int END_HIGH_SEG = 4 * NUM_SYMBOLS + 1;
  localparam int END_LOW_SEG  = 4 * NUM_SYMBOLS + 2;
  localparam int CYCLE_LIMIT  = 500000;

  localparam logic [INDEX_BITS-1:0] UNUSED_INDEX_A = 3'd6;
  localparam logic [INDEX_BITS-1:0] UNUSED_INDEX_B = 3'd7;

  typedef struct packed {
    logic rejected;
    logic sequence_done;
    logic busy;
    logic pin;
  } pin_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index  = '0;
  logic [TICK_BITS-1:0]  cfg_data   = '0;

  int src_idle_pct  = 27;
  int sink_idle_pct = 84;
  int mismatches    = 0;

  pin_result_t expected_pins[$];

  cfg_regs_t            enc_cfg;
  logic                 enc_active;
  logic                 enc_level;
  logic [5:0]           enc_seg;
  logic [TICK_BITS-1:0] enc_presc;
  logic [UNIT_BITS-1:0] enc_units;
  logic [REP_BITS-1:0]  enc_reps;
  logic [2*FIELD_W:0]   enc_word;

  ook_remote_switch_frame_encoder #(.FIELD_BITS(FIELD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  function automatic int unsigned floor_one(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic logic symbol_value(int unsigned sym);
    if (sym < 2 * FIELD_W) return enc_word[sym];
    if (sym == 2 * FIELD_W) return ~enc_word[2*FIELD_W];
    return enc_word[2*FIELD_W];
  endfunction

  function automatic int unsigned segment_units(input int unsigned s, output logic lvl);
    int unsigned sh;
    int unsigned lg;
    int unsigned part;
    logic b;
    sh = floor_one(enc_cfg.short_units);
    lg = floor_one(enc_cfg.long_units);
    if (s == 0) begin
      lvl = 1'b0;
      return enc_cfg.start_gap_units;
    end
    if (s == END_HIGH_SEG) begin
      lvl = 1'b1;
      return sh;
    end
    if (s == END_LOW_SEG) begin
      lvl = 1'b0;
      return floor_one(enc_cfg.end_gap_units);
    end
    part = (s - 1) % 4;
    b = symbol_value((s - 1) / 4);
    lvl = (part % 2 == 0);
    case (part)
      0: return sh;
      1: return lg;
      2: return b ? sh : lg;
      default: return b ? lg : sh;
    endcase
  endfunction

  function automatic void load_segment(int unsigned s);
    int unsigned n;
    logic lvl;
    n = segment_units(s, lvl);
    if (n == 0) begin
      s = 1;
      n = segment_units(s, lvl);
    end
    enc_seg   = 6'(s);
    enc_units = UNIT_BITS'(n);
    enc_level = lvl;
  endfunction

  function automatic pin_result_t encoder_step(logic kind, logic [FIELD_W-1:0] unit_code,
                                               logic [FIELD_W-1:0] device_id, logic switch_off);
    pin_result_t r;
    r = '0;
    if (kind == KIND_SEND) begin
      if (enc_active) begin
        r.rejected = 1'b1;
      end else begin
        enc_word   = {switch_off, device_id, unit_code};
        enc_reps   = REP_BITS'(floor_one(enc_cfg.frame_repeats));
        enc_presc  = '0;
        enc_active = 1'b1;
        load_segment(0);
      end
    end else if (enc_active) begin
      enc_presc = enc_presc + 1'b1;
      if (enc_presc >= floor_one(enc_cfg.ticks_per_unit)) begin
        enc_presc = '0;
        if (enc_units > 0) enc_units = enc_units - 1'b1;
        if (enc_units == 0) begin
          if (enc_seg >= END_LOW_SEG) begin
            if (enc_reps > 0) enc_reps = enc_reps - 1'b1;
            if (enc_reps == 0) begin
              enc_active      = 1'b0;
              enc_level       = 1'b0;
              enc_seg         = '0;
              r.sequence_done = 1'b1;
            end else begin
              load_segment(0);
            end
          end else begin
            load_segment(enc_seg + 1);
          end
        end
      end
    end
    r.pin  = enc_level;
    r.busy = enc_active;
    return r;
  endfunction

  task automatic send_item(input logic kind, input logic [FIELD_W-1:0] unit_code,
                           input logic [FIELD_W-1:0] device_id, input logic switch_off);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, switch_off, device_id, unit_code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_pins.push_back(encoder_step(kind, unit_code, device_id, switch_off));
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, 5'($urandom_range(31)), 5'($urandom_range(31)),
              1'($urandom_range(1)));
  endtask

  task automatic run_to_completion();
    while (enc_active) send_tick();
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [INDEX_BITS-1:0] idx, input logic [TICK_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TICKS_PER_UNIT:  enc_cfg.ticks_per_unit  = data;
      REG_FRAME_REPEATS:   enc_cfg.frame_repeats   = data[REP_BITS-1:0];
      REG_START_GAP_UNITS: enc_cfg.start_gap_units = data[UNIT_BITS-1:0];
      REG_SHORT_UNITS:     enc_cfg.short_units     = data[UNIT_BITS-1:0];
      REG_LONG_UNITS:      enc_cfg.long_units      = data[UNIT_BITS-1:0];
      REG_END_GAP_UNITS:   enc_cfg.end_gap_units   = data[UNIT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_encoder(input logic [TICK_BITS-1:0] tpu, input logic [TICK_BITS-1:0] reps,
                                 input logic [TICK_BITS-1:0] start_gap,
                                 input logic [TICK_BITS-1:0] short_part,
                                 input logic [TICK_BITS-1:0] long_part,
                                 input logic [TICK_BITS-1:0] end_gap);
    put_reg(REG_TICKS_PER_UNIT, tpu);
    put_reg(REG_FRAME_REPEATS, reps);
    put_reg(REG_START_GAP_UNITS, start_gap);
    put_reg(REG_SHORT_UNITS, short_part);
    put_reg(REG_LONG_UNITS, long_part);
    put_reg(REG_END_GAP_UNITS, end_gap);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TICK_BITS-1:0] random_units();
    logic [UNIT_BITS-1:0] u;
    u = ($urandom_range(4) == 0) ? UNIT_BITS'($urandom_range(2, 3))
                                 : UNIT_BITS'($urandom_range(1));
    return {2'($urandom_range(3)), u};
  endfunction

  task automatic test_idle_ticks();
    send_item(KIND_TICK, 5'd31, 5'd31, 1'b1);
    send_item(KIND_TICK, 5'd0, 5'd0, 1'b0);
    settle();
  endtask

  task automatic test_reset_timing();
    send_item(KIND_SEND, 5'd0, 5'd0, 1'b0);
    repeat (3) send_tick();
    send_item(KIND_SEND, 5'd31, 5'd31, 1'b1);
    settle();
    // zero settings written while the reset-config sequence runs
    program_encoder(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    run_to_completion();
    send_item(KIND_SEND, 5'd0, 5'd31, 1'b1);
    run_to_completion();
    send_tick();
    settle();
  endtask

  task automatic test_slow_unit();
    program_encoder(10'd300, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
    send_item(KIND_SEND, 5'd31, 5'd0, 1'b0);
    repeat (305) send_tick();
    settle();
    program_encoder(10'd0, 10'd1, 10'd0, 10'd0, 10'd0, 10'd0);
    run_to_completion();
    settle();
  endtask

  task automatic test_extreme_regs();
    program_encoder(10'h3FF, 10'h3F1, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
    send_item(KIND_SEND, 5'd21, 5'd10, 1'b1);
    repeat (4) send_tick();
    send_item(KIND_SEND, 5'd10, 5'd21, 1'b0);
    settle();
    program_encoder(10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd2);
    run_to_completion();
    settle();
  endtask

  task automatic test_unused_index();
    put_reg(UNUSED_INDEX_A, 10'h3FF);
    put_reg(UNUSED_INDEX_B, 10'h000);
    cfg_valid <= 1'b0;
    send_item(KIND_SEND, 5'd5, 5'd26, 1'b0);
    run_to_completion();
    settle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int per_setting;
    logic kind;
    per_setting = n_items / 9;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct  = 27;
          sink_idle_pct = 84;
        end
        1: begin
          src_idle_pct  = 84;
          sink_idle_pct = 27;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        settle();
        program_encoder(($urandom_range(3) == 0) ? 10'd2 : 10'($urandom_range(1)),
                        {6'($urandom_range(63)), 4'($urandom_range(2))},
                        random_units(), random_units(), random_units(), random_units());
        for (int i = 0; i < per_setting; i++) begin
          if (enc_active) kind = ($urandom_range(99) < 92) ? KIND_TICK : KIND_SEND;
          else kind = ($urandom_range(99) < 60) ? KIND_SEND : KIND_TICK;
          send_item(kind, 5'($urandom_range(31)), 5'($urandom_range(31)),
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    pin_result_t got;
    pin_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = pin_result_t'(out_tdata[3:0]);
      if (expected_pins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result pin %0b busy %0b done %0b rejected %0b",
                   $realtime, got.pin, got.busy, got.sequence_done, got.rejected);
      end else begin
        want = expected_pins.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: wrong result, expected pin %0b busy %0b done %0b rejected %0b,",
                      " got pin %0b busy %0b done %0b rejected %0b"},
                     $realtime, want.pin, want.busy, want.sequence_done, want.rejected,
                     got.pin, got.busy, got.sequence_done, got.rejected);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ook_remote_switch_frame_encoder: mismatch");
    $finish;
  end

  initial begin
    enc_cfg    = {RST_TICKS_PER_UNIT, RST_FRAME_REPEATS, RST_START_GAP_UNITS,
                  RST_SHORT_UNITS, RST_LONG_UNITS, RST_END_GAP_UNITS};
    enc_active = 1'b0;
    enc_level  = 1'b0;
    enc_seg    = '0;
    enc_presc  = '0;
    enc_units  = '0;
    enc_reps   = '0;
    enc_word   = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_reset_timing();
    test_slow_unit();
    test_extreme_regs();
    test_unused_index();
    test_random_traffic(450);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pins.size() == 0) begin
      $display("ook_remote_switch_frame_encoder: match");
    end else begin
      $display("ook_remote_switch_frame_encoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/ookrs_pkg.sv
sv/ookrs_segment_decode.sv
sv/ook_remote_switch_frame_encoder.sv
tb/ook_remote_switch_frame_encoder_tb.sv
